// File: rtl/qte_pkg.sv
// Shared constants, widths and the arctangent table for the quaternion to
// roll, pitch and yaw converter. No dependencies.
`default_nettype none
package qte_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int NSTEP        = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int CORDIC_LAT   = NSTEP + 2;
  localparam int SQ_STEPS     = 32;
  localparam int RY_DLY       = SQ_STEPS + 1;

  localparam int QW = 16;
  localparam int PW = 32;
  localparam int TW = 34;
  localparam int CW = 37;
  localparam int ZW = 29;
  localparam int AW = 16;
  localparam int RW = 63;

  localparam logic signed [TW-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [ZW-1:0] ANG_PI_Q24  = 29'sd52707179;
  localparam logic signed [AW-1:0] PI_Q13      = 16'sd25736;
  localparam logic signed [14:0]   HALF_PI_Q13 = 15'sd12868;

  function automatic logic [23:0] atan_q24(input int unsigned idx);
    case (idx)
      0:  return 24'd13176795;
      1:  return 24'd7778716;
      2:  return 24'd4110060;
      3:  return 24'd2086331;
      4:  return 24'd1047214;
      5:  return 24'd524117;
      6:  return 24'd262123;
      7:  return 24'd131069;
      8:  return 24'd65536;
      9:  return 24'd32768;
      10: return 24'd16384;
      11: return 24'd8192;
      12: return 24'd4096;
      13: return 24'd2048;
      14: return 24'd1024;
      15: return 24'd512;
      16: return 24'd256;
      17: return 24'd128;
      18: return 24'd64;
      19: return 24'd32;
      20: return 24'd16;
      21: return 24'd8;
      22: return 24'd4;
      23: return 24'd2;
      default: return 24'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: rtl/qte_cordic.sv
// Pipelined four-quadrant CORDIC arctangent, one vectoring step per stage.
// Depends on qte_pkg for widths, step count and the arctangent table.
`default_nettype none
module qte_cordic import qte_pkg::*; (
  input  wire logic                 clk,
  input  wire logic signed [CW-1:0] sy,
  input  wire logic signed [CW-1:0] cx,
  output logic signed [AW-1:0]      angle
);

  logic signed [CW-1:0] x_r [0:NSTEP];
  logic signed [CW-1:0] y_r [0:NSTEP];
  logic signed [ZW-1:0] z_r [0:NSTEP];
  logic                 zero_r [0:NSTEP];
  logic signed [AW-1:0] angle_r;

  // fold the left half plane onto the right
  always_ff @(posedge clk) begin
    zero_r[0] <= (cx == '0) && (sy == '0);
    if (cx[CW-1]) begin
      x_r[0] <= -cx;
      y_r[0] <= -sy;
      z_r[0] <= sy[CW-1] ? -ANG_PI_Q24 : ANG_PI_Q24;
    end else begin
      x_r[0] <= cx;
      y_r[0] <= sy;
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    localparam logic signed [ZW-1:0] AT = ZW'(atan_q24(i));
    logic signed [CW-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      zero_r[i+1] <= zero_r[i];
      if (!y_r[i][CW-1]) begin
        x_r[i+1] <= x_r[i] + ys;
        y_r[i+1] <= y_r[i] - xs;
        z_r[i+1] <= z_r[i] + AT;
      end else begin
        x_r[i+1] <= x_r[i] - ys;
        y_r[i+1] <= y_r[i] + xs;
        z_r[i+1] <= z_r[i] - AT;
      end
    end
  end

  logic signed [ZW-1:0]    zrnd;
  logic signed [ZW-12:0]   zq;
  logic signed [AW-1:0]    angle_nxt;
  assign zrnd = z_r[NSTEP] + ZW'(1024);
  assign zq   = zrnd[ZW-1:11];

  always_comb begin
    if (zero_r[NSTEP]) begin
      angle_nxt = '0;
    end else if (zq > (ZW-11)'(PI_Q13)) begin
      angle_nxt = PI_Q13;
    end else if (zq < -((ZW-11)'(PI_Q13))) begin
      angle_nxt = -PI_Q13;
    end else begin
      angle_nxt = zq[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

  assign angle = angle_r;

endmodule
`default_nettype wire

// File: rtl/quaternion_to_euler_angles_top.sv
// Quaternion to ZYX roll, pitch and yaw converter, fully pipelined.
// Depends on qte_pkg and qte_cordic.
`default_nettype none
// Usage:
//   Present a quaternion on in_quat_x/y/z/w (signed Q1.15) and raise start.
//   busy is always low, so a transaction is taken at every edge with start
//   high; one quaternion may enter every cycle.
//   Each result appears on out_roll_angle, out_pitch_angle, out_yaw_angle
//   (signed Q2.13 radians; the pitch is signed Q1.13) and out_pitch_saturated
//   for exactly one cycle, marked by out_valid, in input order.
//   The path runs through registered stages of products, terms and squaring,
//   a 32-stage square-root pipeline for the pitch cosine, the pitch CORDIC
//   pipeline and an output register. Roll and yaw run their CORDIC pipelines
//   in parallel and are delayed to line up. Throughput is one result per cycle.
//   Synchronous reset clears every valid bit; items in flight are dropped.
//   The receiver cannot stall the block, so no back-pressure exists.
module quaternion_to_euler_angles_top import qte_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic signed [QW-1:0] in_quat_x,
  input  wire logic signed [QW-1:0] in_quat_y,
  input  wire logic signed [QW-1:0] in_quat_z,
  input  wire logic signed [QW-1:0] in_quat_w,
  output logic                      out_valid,
  output logic signed [AW-1:0]      out_roll_angle,
  output logic signed [14:0]        out_pitch_angle,
  output logic signed [AW-1:0]      out_yaw_angle,
  output logic                      out_pitch_saturated
);

  assign busy = 1'b0;

  // stage 1: products
  logic v1_r;
  logic signed [PW-1:0] wx_r, yz_r, xx_r, yy_r, wy_r, zx_r, wz_r, xy_r, zz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    wx_r <= in_quat_w * in_quat_x;
    yz_r <= in_quat_y * in_quat_z;
    xx_r <= in_quat_x * in_quat_x;
    yy_r <= in_quat_y * in_quat_y;
    wy_r <= in_quat_w * in_quat_y;
    zx_r <= in_quat_z * in_quat_x;
    wz_r <= in_quat_w * in_quat_z;
    xy_r <= in_quat_x * in_quat_y;
    zz_r <= in_quat_z * in_quat_z;
  end

  // stage 2: sine and cosine terms
  logic v2_r;
  logic signed [TW-1:0] sinr_r, cosr_r, sinp_r, siny_r, cosy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sinr_r <= (TW'(wx_r) + TW'(yz_r)) <<< 1;
    cosr_r <= ONE_Q30 - ((TW'(xx_r) + TW'(yy_r)) <<< 1);
    sinp_r <= (TW'(wy_r) - TW'(zx_r)) <<< 1;
    siny_r <= (TW'(wz_r) + TW'(xy_r)) <<< 1;
    cosy_r <= ONE_Q30 - ((TW'(yy_r) + TW'(zz_r)) <<< 1);
  end

  // stage 3: pitch magnitude, saturation, square
  logic v3_r, sat3_r;
  logic signed [TW-1:0] sinp3_r;
  logic [59:0] sq3_r;
  logic signed [TW-1:0] mag;
  logic [29:0] m30;

  assign mag = sinp_r[TW-1] ? -sinp_r : sinp_r;
  assign m30 = mag[29:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    sat3_r  <= mag >= ONE_Q30;
    sinp3_r <= sinp_r;
    sq3_r   <= 60'(m30) * 60'(m30);
  end

  // square-root pipeline, one result bit per stage
  logic [RW-1:0]        sn_r [0:SQ_STEPS-1];
  logic [RW-1:0]        sr_r [0:SQ_STEPS-1];
  logic signed [TW-1:0] ss_r [0:SQ_STEPS-1];
  logic                 st_r [0:SQ_STEPS-1];
  logic                 sv_r [0:SQ_STEPS-1];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (62 - 2 * k);
    logic [RW-1:0]        nin, rin, trial;
    logic signed [TW-1:0] sin_i;
    logic                 sat_i, v_i;
    if (k == 0) begin : g_first
      assign nin   = (RW'(1) << 60) - RW'(sq3_r);
      assign rin   = '0;
      assign sin_i = sinp3_r;
      assign sat_i = sat3_r;
      assign v_i   = v3_r;
    end else begin : g_next
      assign nin   = sn_r[k-1];
      assign rin   = sr_r[k-1];
      assign sin_i = ss_r[k-1];
      assign sat_i = st_r[k-1];
      assign v_i   = sv_r[k-1];
    end
    assign trial = rin + BIT;
    always_ff @(posedge clk) begin
      ss_r[k] <= sin_i;
      st_r[k] <= sat_i;
      if (nin >= trial) begin
        sn_r[k] <= nin - trial;
        sr_r[k] <= (rin >> 1) + BIT;
      end else begin
        sn_r[k] <= nin;
        sr_r[k] <= rin >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else begin
        sv_r[k] <= v_i;
      end
    end
  end

  // arctangent pipelines
  logic signed [AW-1:0] roll_a, yaw_a, pitch_a;
  logic signed [CW-1:0] pcx;

  assign pcx = CW'(sr_r[SQ_STEPS-1][30:0]);

  qte_cordic u_roll (
    .clk   (clk),
    .sy    (CW'(sinr_r)),
    .cx    (CW'(cosr_r)),
    .angle (roll_a)
  );

  qte_cordic u_yaw (
    .clk   (clk),
    .sy    (CW'(siny_r)),
    .cx    (CW'(cosy_r)),
    .angle (yaw_a)
  );

  qte_cordic u_pitch (
    .clk   (clk),
    .sy    (CW'(ss_r[SQ_STEPS-1])),
    .cx    (pcx),
    .angle (pitch_a)
  );

  // hold roll and yaw until pitch catches up
  logic signed [AW-1:0] rd_r [0:RY_DLY-1];
  logic signed [AW-1:0] yd_r [0:RY_DLY-1];

  for (genvar k = 0; k < RY_DLY; k++) begin : g_rydly
    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        rd_r[k] <= roll_a;
        yd_r[k] <= yaw_a;
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        rd_r[k] <= rd_r[k-1];
        yd_r[k] <= yd_r[k-1];
      end
    end
  end

  // carry pitch side bits alongside the pitch CORDIC
  logic pd_sat_r [0:CORDIC_LAT-1];
  logic pd_neg_r [0:CORDIC_LAT-1];
  logic pd_v_r   [0:CORDIC_LAT-1];

  for (genvar k = 0; k < CORDIC_LAT; k++) begin : g_pdly
    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        pd_sat_r[k] <= st_r[SQ_STEPS-1];
        pd_neg_r[k] <= ss_r[SQ_STEPS-1][TW-1];
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          pd_v_r[k] <= 1'b0;
        end else begin
          pd_v_r[k] <= sv_r[SQ_STEPS-1];
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        pd_sat_r[k] <= pd_sat_r[k-1];
        pd_neg_r[k] <= pd_neg_r[k-1];
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          pd_v_r[k] <= 1'b0;
        end else begin
          pd_v_r[k] <= pd_v_r[k-1];
        end
      end
    end
  end

  // output register
  logic                 out_valid_r, out_sat_r;
  logic signed [AW-1:0] out_roll_r, out_yaw_r;
  logic signed [14:0]   out_pitch_r, pitch_nxt;

  always_comb begin
    if (pd_sat_r[CORDIC_LAT-1]) begin
      pitch_nxt = pd_neg_r[CORDIC_LAT-1] ? -HALF_PI_Q13 : HALF_PI_Q13;
    end else if (pitch_a > AW'(HALF_PI_Q13)) begin
      pitch_nxt = HALF_PI_Q13;
    end else if (pitch_a < -(AW'(HALF_PI_Q13))) begin
      pitch_nxt = -HALF_PI_Q13;
    end else begin
      pitch_nxt = pitch_a[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pd_v_r[CORDIC_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_roll_r  <= rd_r[RY_DLY-1];
    out_yaw_r   <= yd_r[RY_DLY-1];
    out_pitch_r <= pitch_nxt;
    out_sat_r   <= pd_sat_r[CORDIC_LAT-1];
  end

  assign out_valid           = out_valid_r;
  assign out_roll_angle      = out_roll_r;
  assign out_pitch_angle     = out_pitch_r;
  assign out_yaw_angle       = out_yaw_r;
  assign out_pitch_saturated = out_sat_r;

  a_sat_pitch : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pitch_saturated |->
      (out_pitch_angle == HALF_PI_Q13) || (out_pitch_angle == -HALF_PI_Q13))
    else $error("saturated pitch not at a pole");

  a_pitch_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= HALF_PI_Q13) && (out_pitch_angle >= -HALF_PI_Q13))
    else $error("pitch out of range");

  a_roll_yaw_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_angle <= PI_Q13) && (out_roll_angle >= -PI_Q13) &&
                  (out_yaw_angle <= PI_Q13) && (out_yaw_angle >= -PI_Q13))
    else $error("roll or yaw out of range");

endmodule
`default_nettype wire
